### rtl/hsbs_pkg.sv
// ----------------------------------------------------------------------------
// hsbs_pkg
// Shared types and constants for the scaled HMM backward step core.
// ----------------------------------------------------------------------------
package hsbs_pkg;

   localparam int MAX_STATES_DEF = 16;
   localparam int PROB_BITS_DEF  = 32;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_RESTART = 2'd1;
   localparam logic [1:0] FUNC_EMIT    = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  row_index;
      logic [3:0]  col_index;
      logic [31:0] value;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic [3:0]  state_index;
      logic [31:0] beta_value;
      logic        zero_norm;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UNI,
      ST_MAC_RD,
      ST_MAC_M1,
      ST_MAC_M2,
      ST_MAC_ACC,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_tab;
      logic       load_emit;
      logic       uni_start;
      logic       uni_step;
      logic       clr_acc;
      logic       mac_rd;
      logic       mac_m1;
      logic       mac_m2;
      logic       mac_acc;
      logic       row_done;
      logic       div_start;
      logic       div_step;
      logic       div_store;
      logic       zero_store;
      logic       out_rd;
      logic       set_zflag;
      logic       clr_zflag;
      logic [3:0] i_idx;
      logic [3:0] j_idx;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic total_zero;
      logic div_done;
      logic uni_done;
   } sts_type;

endpackage

### rtl/hmm_scaled_backward_step_core.sv
// One item at a time: a restart or an update runs until its last beat is taken,
// and req_ready stays low until then. Each gives one beat per active state, in
// state order. Updates share one multiplier and a bit-serial divider. Load and
// emission items are taken in the idle state.
// Reset (synchronous) sets state_count to 16 and each beta entry to 1/16.
// ----------------------------------------------------------------------------
// hmm_scaled_backward_step_core
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
module hmm_scaled_backward_step_core #(
   parameter int MAX_STATES = hsbs_pkg::MAX_STATES_DEF,
   parameter int PROB_BITS  = hsbs_pkg::PROB_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsbs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsbs_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);
   import hsbs_pkg::*;

   localparam int LIM = (MAX_STATES < 16) ? MAX_STATES : 16;

   logic [4:0] count_ff;
   logic [4:0] n_states;
   cmd_type    cmd;
   sts_type    sts;
   logic [31:0] beta;
   logic        zflag, last;
   logic [3:0]  idx;

   // state count register
   always_ff @(posedge clock) begin
      if (reset) count_ff <= 5'd16;
      else if (csr_we) count_ff <= csr_wdata;
   end

   always_comb begin
      if (count_ff < 5'd2) n_states = 5'd2;
      else if (count_ff > 5'(LIM)) n_states = 5'(LIM);
      else n_states = count_ff;
   end

   hsbs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data, .n_states,
      .rsp_valid, .rsp_ready, .rsp_last(last), .rsp_idx(idx), .cmd, .sts
   );

   hsbs_dp #(.MAX_STATES(MAX_STATES), .PROB_BITS(PROB_BITS)) u_dp (
      .clock, .reset, .req_data, .n_states, .cmd, .sts,
      .beta_out(beta), .zflag
   );

   assign rsp_data.state_index = idx;
   assign rsp_data.beta_value  = beta;
   assign rsp_data.zero_norm   = zflag;
   assign rsp_data.last_of_run = last;

endmodule

### rtl/hsbs_ctrl.sv
// ----------------------------------------------------------------------------
// hsbs_ctrl
// Sequencer: walks the restart, multiply-accumulate, divide and output phases.
// ----------------------------------------------------------------------------
module hsbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsbs_pkg::req_type req_data,
   input  logic [4:0]        n_states,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_last,
   output logic [3:0]        rsp_idx,
   output hsbs_pkg::cmd_type cmd,
   input  hsbs_pkg::sts_type sts
);
   import hsbs_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] i_ff, i_in, j_ff, j_in;
   logic       valid_ff, valid_in;
   logic [3:0] last_idx;
   logic       acc;

   assign last_idx = 4'(n_states - 5'd1);
   assign acc      = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_idx   = i_ff;
   assign rsp_last  = (i_ff == last_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            if (acc && req_data.func == FUNC_RESTART) begin
               state_in = ST_UNI;
            end else if (acc && req_data.func == FUNC_EMIT && req_data.last_element) begin
               state_in = ST_MAC_RD;
            end
         end
         ST_UNI: begin
            if (sts.uni_done) state_in = ST_OUT_RD;
         end
         ST_MAC_RD:  state_in = ST_MAC_M1;
         ST_MAC_M1:  state_in = ST_MAC_M2;
         ST_MAC_M2:  state_in = ST_MAC_ACC;
         ST_MAC_ACC: begin
            if (j_ff == last_idx) begin
               j_in = '0;
               if (i_ff == last_idx) begin
                  i_in     = '0;
                  state_in = ST_DIV_START;
               end else begin
                  i_in     = i_ff + 4'd1;
                  state_in = ST_MAC_RD;
               end
            end else begin
               j_in     = j_ff + 4'd1;
               state_in = ST_MAC_RD;
            end
         end
         ST_DIV_START: begin
            if (sts.total_zero) begin
               if (i_ff == last_idx) begin
                  i_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in = i_ff + 4'd1;
               end
            end else begin
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            if (sts.div_done) begin
               if (i_ff == last_idx) begin
                  i_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in     = i_ff + 4'd1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_OUT_RD: begin
            valid_in = 1'b1;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (i_ff == last_idx) begin
                  i_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 4'd1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.i_idx = i_ff;
      cmd.j_idx = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_tab   = acc && req_data.func == FUNC_LOAD;
            cmd.load_emit  = acc && req_data.func == FUNC_EMIT;
            cmd.uni_start  = acc && req_data.func == FUNC_RESTART;
            cmd.clr_zflag  = acc && req_data.func == FUNC_RESTART;
            cmd.clr_acc    = acc && req_data.func == FUNC_EMIT;
         end
         ST_UNI:     cmd.uni_step = 1'b1;
         ST_MAC_RD:  cmd.mac_rd = 1'b1;
         ST_MAC_M1:  cmd.mac_m1 = 1'b1;
         ST_MAC_M2:  cmd.mac_m2 = 1'b1;
         ST_MAC_ACC: begin
            cmd.mac_acc  = 1'b1;
            cmd.row_done = (j_ff == last_idx);
         end
         ST_DIV_START: begin
            cmd.div_start  = !sts.total_zero;
            cmd.zero_store = sts.total_zero;
            cmd.set_zflag  = sts.total_zero;
            cmd.clr_zflag  = !sts.total_zero;
         end
         ST_DIV_RUN: begin
            cmd.div_step  = 1'b1;
            cmd.div_store = sts.div_done;
         end
         ST_OUT_RD:   cmd.out_rd = 1'b1;
         ST_OUT_SEND: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/hsbs_dp.sv
// ----------------------------------------------------------------------------
// hsbs_dp
// Datapath: tables, two-stage product, accumulators and a restoring divider.
// ----------------------------------------------------------------------------
module hsbs_dp #(
   parameter int MAX_STATES = hsbs_pkg::MAX_STATES_DEF,
   parameter int PROB_BITS  = hsbs_pkg::PROB_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  hsbs_pkg::req_type req_data,
   input  logic [4:0]        n_states,
   input  hsbs_pkg::cmd_type cmd,
   output hsbs_pkg::sts_type sts,
   output logic [31:0]       beta_out,
   output logic              zflag
);
   import hsbs_pkg::*;

   localparam int FRAC  = PROB_BITS - 1;
   localparam int SUMW  = PROB_BITS + 8;
   localparam int TABD  = MAX_STATES * MAX_STATES;
   localparam int IW    = $clog2(MAX_STATES);
   localparam int TW    = $clog2(TABD);
   localparam int CW    = $clog2(PROB_BITS + 1);
   localparam logic [PROB_BITS-1:0] PMAX = '1;
   localparam logic [SUMW-1:0] ONE_Q = SUMW'(1) << FRAC;

   logic [PROB_BITS-1:0] tab_mem [TABD];
   logic [PROB_BITS-1:0] emit_mem [MAX_STATES];
   logic [PROB_BITS-1:0] beta_ff [MAX_STATES];
   logic [SUMW-1:0]      sum_mem [MAX_STATES];

   logic [PROB_BITS-1:0] a_ff, b_ff, e_ff, e2_ff, t_ff, p_ff;
   logic [SUMW-1:0]      acc_ff, total_ff;
   logic [SUMW-1:0]      rem_ff;
   logic [PROB_BITS-1:0] q_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 div_run_ff, zflag_ff;
   logic [PROB_BITS-1:0] out_ff;
   logic [SUMW-1:0]      uni_rem_ff;
   logic [PROB_BITS-1:0] uni_q_ff;
   logic [CW-1:0]        uni_cnt_ff;
   logic                 uni_run_ff;

   logic [2*PROB_BITS-1:0] prod;
   logic [PROB_BITS-1:0]   prod_sat;
   logic [SUMW:0]          rem_sh;
   logic [SUMW-1:0]        uni_sh, den_n;
   logic                   ge, uge;
   logic [IW-1:0]          ii, jj;
   logic [TW-1:0]          tab_wr, tab_rd;
   logic                   tab_wr_ok, emit_wr_ok;

   assign ii = IW'(cmd.i_idx);
   assign jj = IW'(cmd.j_idx);

   // table addresses, row major; entries outside the table are dropped
   assign tab_wr = TW'(req_data.row_index) * TW'(MAX_STATES) + TW'(req_data.col_index);
   assign tab_rd = TW'(ii) * TW'(MAX_STATES) + TW'(jj);
   assign tab_wr_ok  = (int'(req_data.row_index) < MAX_STATES) &&
                       (int'(req_data.col_index) < MAX_STATES);
   assign emit_wr_ok = (int'(req_data.col_index) < MAX_STATES);

   // shared multiplier: a*beta then t*e, shifted and saturated
   always_comb begin
      prod = cmd.mac_m1 ? (2*PROB_BITS)'(a_ff) * (2*PROB_BITS)'(b_ff)
                        : (2*PROB_BITS)'(t_ff) * (2*PROB_BITS)'(e2_ff);
      if ((prod >> FRAC) > (2*PROB_BITS)'(PMAX)) prod_sat = PMAX;
      else prod_sat = PROB_BITS'(prod >> FRAC);
   end

   // table and emission stores
   always_ff @(posedge clock) begin
      if (cmd.load_tab && tab_wr_ok) tab_mem[tab_wr] <= PROB_BITS'(req_data.value);
      if (cmd.load_emit && emit_wr_ok)
         emit_mem[IW'(req_data.col_index)] <= PROB_BITS'(req_data.value);
      if (cmd.mac_rd) begin
         a_ff <= tab_mem[tab_rd];
         e_ff <= emit_mem[jj];
      end
   end

   // multiply-accumulate path
   always_ff @(posedge clock) begin
      if (cmd.mac_rd) b_ff <= beta_ff[jj];
      if (cmd.mac_m1) begin
         t_ff  <= prod_sat;
         e2_ff <= e_ff;
      end
      if (cmd.mac_m2) p_ff <= prod_sat;
      if (cmd.row_done) sum_mem[ii] <= acc_ff + SUMW'(p_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_acc) begin
         acc_ff   <= '0;
         total_ff <= '0;
      end else if (cmd.mac_acc) begin
         total_ff <= total_ff + SUMW'(p_ff);
         if (cmd.row_done) acc_ff <= '0;
         else acc_ff <= acc_ff + SUMW'(p_ff);
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff, 1'b0};
   assign ge     = rem_sh >= {1'b0, total_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
         cnt_ff     <= '0;
      end else if (cmd.div_start) begin
         div_run_ff <= 1'b1;
         cnt_ff     <= '0;
      end else if (cmd.div_step && div_run_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == CW'(FRAC - 1)) div_run_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         if (sum_mem[ii] >= total_ff) begin
            q_ff   <= PROB_BITS'(1);
            rem_ff <= sum_mem[ii] - total_ff;
         end else begin
            q_ff   <= '0;
            rem_ff <= sum_mem[ii];
         end
      end else if (cmd.div_step && div_run_ff) begin
         q_ff   <= {q_ff[PROB_BITS-2:0], ge};
         rem_ff <= ge ? SUMW'(rem_sh - {1'b0, total_ff}) : SUMW'(rem_sh);
      end
   end
   assign sts.div_done   = cmd.div_step && !div_run_ff;
   assign sts.total_zero = (total_ff == '0);

   // uniform value: floor(1.0 / n) by the same bit-serial method
   assign den_n  = SUMW'(n_states);
   assign uni_sh = uni_rem_ff << 1;
   assign uge    = uni_sh >= den_n;
   always_ff @(posedge clock) begin
      if (reset) begin
         uni_run_ff <= 1'b0;
         uni_cnt_ff <= '0;
      end else if (cmd.uni_start) begin
         uni_run_ff <= 1'b1;
         uni_cnt_ff <= '0;
      end else if (cmd.uni_step && uni_run_ff) begin
         uni_cnt_ff <= uni_cnt_ff + CW'(1);
         if (uni_cnt_ff == CW'(PROB_BITS - 1)) uni_run_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.uni_start) begin
         uni_rem_ff <= '0;
         uni_q_ff   <= '0;
      end else if (cmd.uni_step && uni_run_ff) begin
         uni_q_ff   <= {uni_q_ff[PROB_BITS-2:0], uge};
         uni_rem_ff <= (uge ? uni_sh - den_n : uni_sh) | SUMW'(uni_cnt_ff == CW'(0));
      end
   end
   assign sts.uni_done = cmd.uni_step && !uni_run_ff;

   // beta vector and zero flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_STATES; k++) beta_ff[k] <= PROB_BITS'(ONE_Q >> 4);
         zflag_ff <= 1'b0;
      end else begin
         if (sts.uni_done)
            for (int k = 0; k < MAX_STATES; k++)
               if (k < int'(n_states)) beta_ff[k] <= uni_q_ff;
         if (cmd.div_store)  beta_ff[ii] <= q_ff;
         if (cmd.zero_store) beta_ff[ii] <= '0;
         if (cmd.set_zflag)  zflag_ff <= 1'b1;
         else if (cmd.clr_zflag) zflag_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_rd) out_ff <= beta_ff[ii];
   end

   assign beta_out = 32'(out_ff);
   assign zflag    = zflag_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the scaled HMM backward step core. A bit-true predictor of the
// recursion produces the expected beats, first for a table of directed items
// and then for random time steps run at several state counts. Both sides of
// the core idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import hsbs_pkg::*;

   typedef struct {
      bit          is_cfg;
      logic [4:0]  cfg_value;
      req_type     item;
      bit          typed;
      logic [31:0] typed_beta;
      bit          typed_zero;
   } dir_row_t;

   localparam int NUM_DIR = 22;
   localparam int FILL_STATES = 8;
   localparam logic [31:0] Q_ONE  = 32'h8000_0000;
   localparam logic [31:0] Q_FULL = 32'hFFFF_FFFF;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic [4:0] csr_wdata;

   // predictor state
   logic [31:0] trans_tab [16][16];
   logic [31:0] beta_vec [16];
   logic [31:0] emis_vec [16];
   logic [4:0]  count_reg;
   rsp_type     step_beats [$];
   rsp_type     expected_beats [$];

   int          mismatches;
   int          idle_mode;
   int          hold_requests;
   int          hold_served;
   int          hold_left;
   int          sent_items;

   // state counts of the random phases, all within the filled table
   logic [4:0] counts [10] = '{5'd5, 5'd8, 5'd0, 5'd7, 5'd6, 5'd2,
                               5'd1, 5'd4, 5'd3, 5'd8};

   dir_row_t dir_rows [NUM_DIR] = '{
      // uniform restart after reset, sixteen states
      '{0, 5'd0, '{FUNC_RESTART, 4'd0, 4'd0, 32'd0, 1'b0}, 1, 32'h0800_0000, 0},
      // unused function code and last flag on a load are ignored
      '{0, 5'd0, '{2'd3, 4'd3, 4'd3, Q_FULL, 1'b1}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_LOAD, 4'd15, 4'd15, 32'h1234_5678, 1'b1}, 0, 32'd0, 0},
      // state count above the limit is clamped to sixteen
      '{1, 5'd31, '{FUNC_LOAD, 4'd0, 4'd0, 32'd0, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_RESTART, 4'd0, 4'd0, 32'd0, 1'b0}, 1, 32'h0800_0000, 0},
      '{1, 5'd2, '{FUNC_LOAD, 4'd0, 4'd0, 32'd0, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_RESTART, 4'd0, 4'd0, 32'd0, 1'b0}, 1, 32'h4000_0000, 0},
      // all transitions and emissions 1.0 keep the uniform vector
      '{0, 5'd0, '{FUNC_LOAD, 4'd0, 4'd0, Q_ONE, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_LOAD, 4'd0, 4'd1, Q_ONE, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_LOAD, 4'd1, 4'd0, Q_ONE, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_LOAD, 4'd1, 4'd1, Q_ONE, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd0, Q_ONE, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd1, Q_ONE, 1'b1}, 1, 32'h4000_0000, 0},
      // zero emissions give a zero total
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd0, 32'd0, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd1, 32'd0, 1'b1}, 1, 32'd0, 1},
      // entry beyond the active states, restart with last flag set
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd15, Q_FULL, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_RESTART, 4'd9, 4'd9, Q_FULL, 1'b1}, 1, 32'h4000_0000, 0},
      // saturating products
      '{0, 5'd0, '{FUNC_LOAD, 4'd0, 4'd0, Q_FULL, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_LOAD, 4'd1, 4'd0, 32'd1, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd0, Q_FULL, 1'b0}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd1, Q_FULL, 1'b1}, 0, 32'd0, 0},
      '{0, 5'd0, '{FUNC_EMIT, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1}, 0, 32'd0, 0}
   };

   hmm_scaled_backward_step_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int active_states();
      int n;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      return n;
   endfunction

   function automatic logic [31:0] q_mul(logic [31:0] x, logic [31:0] y);
      logic [63:0] p;
      p = x * y;
      p = p >> 31;
      return (p > 64'hFFFF_FFFF) ? Q_FULL : p[31:0];
   endfunction

   function automatic logic [31:0] q_div(logic [63:0] s, logic [63:0] total);
      logic [127:0] num;
      logic [127:0] quo;
      num = {64'd0, s} << 31;
      quo = num / {64'd0, total};
      return quo[31:0];
   endfunction

   function automatic void give_vector(int n, logic zflag);
      rsp_type b;
      for (int i = 0; i < n; i++) begin
         b.state_index = i[3:0];
         b.beta_value  = beta_vec[i];
         b.zero_norm   = zflag;
         b.last_of_run = (i == n - 1);
         step_beats.push_back(b);
      end
   endfunction

   // advance the backward recursion by one item, beats go to step_beats
   function automatic void backward_step(req_type r);
      int          n;
      logic [63:0] sums [16];
      logic [63:0] total;
      logic [31:0] t;
      n = active_states();
      step_beats.delete();
      case (r.func)
         FUNC_LOAD: begin
            trans_tab[r.row_index][r.col_index] = r.value;
         end
         FUNC_RESTART: begin
            for (int i = 0; i < n; i++) beta_vec[i] = Q_ONE / n;
            give_vector(n, 1'b0);
         end
         FUNC_EMIT: begin
            emis_vec[r.col_index] = r.value;
            if (r.last_element) begin
               total = 0;
               for (int i = 0; i < n; i++) begin
                  sums[i] = 0;
                  for (int j = 0; j < n; j++) begin
                     t = q_mul(trans_tab[i][j], beta_vec[j]);
                     sums[i] += q_mul(t, emis_vec[j]);
                  end
                  total += sums[i];
               end
               for (int i = 0; i < n; i++)
                  beta_vec[i] = (total == 0) ? 32'd0 : q_div(sums[i], total);
               give_vector(n, total == 0);
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- driving
   function automatic bit sender_waits();
      if (idle_mode == 1) return $urandom_range(0, 99) < 85;
      if (idle_mode == 3) return $urandom_range(0, 99) < 8;
      return 0;
   endfunction

   function automatic logic [31:0] rand_prob();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 32'd0;
         1: return Q_FULL;
         2: return Q_ONE;
         3: return $urandom;
         default: return $urandom_range(0, 32'h8000_0000);
      endcase
   endfunction

   // offer one beat, hold it until taken; typed rows replace the prediction
   task automatic send_item(req_type r, bit typed = 0, logic [31:0] tb = 0,
                            bit tz = 0);
      rsp_type b;
      @(negedge clock);
      while (sender_waits()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      backward_step(r);
      foreach (step_beats[k]) begin
         b = step_beats[k];
         if (typed) begin
            b.beta_value = tb;
            b.zero_norm  = tz;
         end
         expected_beats.push_back(b);
      end
   endtask

   task automatic write_count(logic [4:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_beats.size() == 0);
      repeat (10) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      count_reg = v;
   endtask

   task automatic send_time_step(bit broken);
      int n;
      int start;
      int len;
      req_type r;
      n = active_states();
      start = $urandom_range(0, n - 1);
      len = broken ? $urandom_range(1, n) : n;
      for (int k = 0; k < len; k++) begin
         r = '{FUNC_EMIT, 4'($urandom), 4'((start + k) % n), rand_prob(),
               (k == len - 1)};
         send_item(r);
      end
   endtask

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (hold_served < hold_requests) begin
         hold_served++;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_mode == 2)
         rsp_ready <= $urandom_range(0, 99) >= 85;
      else if (idle_mode == 3)
         rsp_ready <= $urandom_range(0, 99) >= 8;
      else
         rsp_ready <= 1'b1;
   end

   // compare each taken result beat with the oldest expected one
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat %h", rsp_data);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat mismatch: state %0d/%0d beta %h/%h zero %b/%b last %b/%b",
                     e.state_index, rsp_data.state_index, e.beta_value,
                     rsp_data.beta_value, e.zero_norm, rsp_data.zero_norm,
                     e.last_of_run, rsp_data.last_of_run);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      int phase;
      int pick;
      req_type r;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      mismatches    = 0;
      idle_mode     = 0;
      hold_requests = 0;
      hold_served   = 0;
      hold_left     = 0;
      sent_items    = 0;
      count_reg     = 5'd16;
      for (int i = 0; i < 16; i++) beta_vec[i] = Q_ONE / 16;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the part of the transition table and emission buffer in use
      for (int i = 0; i < FILL_STATES; i++)
         for (int j = 0; j < FILL_STATES; j++)
            send_item('{FUNC_LOAD, 4'(i), 4'(j), rand_prob(), 1'b0});
      for (int j = 0; j < FILL_STATES; j++)
         send_item('{FUNC_EMIT, 4'd0, 4'(j), rand_prob(), 1'b0});

      // directed table
      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_cfg)
            write_count(dir_rows[k].cfg_value);
         else
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].typed_beta,
                      dir_rows[k].typed_zero);
      end

      // random phases over several state counts and idling modes
      phase = 0;
      while (sent_items < 280) begin
         write_count(counts[phase % 10]);
         idle_mode = phase % 4;
         if (phase == 1) begin
            // long receiver hold-off while restarts keep coming
            hold_requests++;
            repeat (6) send_item('{FUNC_RESTART, 4'd0, 4'd0, 32'd0, 1'b0});
         end
         for (int s = 0; s < 6; s++) begin
            if (phase == 2 && s == 3) begin
               @(negedge clock);
               req_valid <= 1'b0;
               wait (expected_beats.size() == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
               send_time_step(0);
            else if (pick < 73)
               send_time_step(1);
            else if (pick < 83)
               send_item('{FUNC_RESTART, 4'($urandom), 4'($urandom), $urandom,
                           1'($urandom)});
            else if (pick < 92)
               send_item('{FUNC_LOAD, 4'($urandom), 4'($urandom), rand_prob(),
                           1'($urandom)});
            else if (pick < 96)
               send_item('{FUNC_EMIT, 4'($urandom), 4'($urandom), rand_prob(), 1'b0});
            else begin
               r = '{2'd3, 4'($urandom), 4'($urandom), $urandom, 1'($urandom)};
               send_item(r);
            end
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_beats.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
